>>> design/shortest_queue_assigner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest queue assigner
// Clocked property checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_QUEUE_ASSIGNER_DEFINES_SVH
`define SHORTEST_QUEUE_ASSIGNER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check an implication at every rising clock edge outside reset.
`define SQA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SQA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SQA_ASSERT(label, clk, rst, prop, msg)
`define SQA_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

>>> design/sqa_pkg.sv
// ----------------------------------------------------------------------------
// Shortest queue assigner package
// Shared widths, transaction types, controller states and command/status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqa_pkg;

   localparam int LINES_DEFAULT       = 128;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam int LINE_BITS        = 7;
   localparam int LENGTH_OUT_BITS  = 16;
   localparam int LINE_COUNT_BITS  = 8;

   localparam logic [LINE_COUNT_BITS-1:0] LINE_COUNT_RESET = 8'd1;

   typedef enum logic [0:0] {
      FUNC_LOAD   = 1'b0,
      FUNC_ASSIGN = 1'b1
   } func_type;

   typedef struct packed {
      func_type                    func;
      logic [LINE_BITS-1:0]        line_index;
      logic [LENGTH_OUT_BITS-1:0]  load_length;
   } req_type;

   typedef struct packed {
      logic [LINE_BITS-1:0]        chosen_line;
      logic [LENGTH_OUT_BITS-1:0]  chosen_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic clear_write;
      logic load_write;
      logic scan_start;
      logic scan_step;
      logic update_write;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

>>> design/shortest_queue_assigner.sv
// Assign: scans the first line_count queues (clamped to 1..LINES) one memory
// read per cycle, drains the last read, writes the chosen queue back one longer
// (saturating) and loads the result; the next transaction is taken in idle.
// Load: written on acceptance, no result. A stalled earlier response delays
// the result load and the return to idle. After synchronous reset a clearing
// pass zeroes the memory with req_stall high; line_count resets to 1.
// ----------------------------------------------------------------------------
// Shortest queue assigner
// Join-shortest-queue selection over a bank of saturating length counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shortest_queue_assigner #(
   parameter int LINES       = sqa_pkg::LINES_DEFAULT,
   parameter int LENGTH_BITS = sqa_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sqa_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sqa_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [sqa_pkg::LINE_COUNT_BITS-1:0]  csr_write_data
);
   import sqa_pkg::*;

   cmd_type    cmd;
   status_type status;

   sqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sqa_datapath #(
      .LINES       (LINES),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> design/sqa_ctrl.sv
// ----------------------------------------------------------------------------
// Shortest queue assigner controller
// Sequences the clearing pass, loads, the queue scan and the write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  sqa_pkg::func_type    req_func,
   output logic                 req_stall,
   input  sqa_pkg::status_type  status,
   output sqa_pkg::cmd_type     cmd
);
   import sqa_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   assign req_accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept && (req_func == FUNC_ASSIGN)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
         end
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.load_write = req_accept && (req_func == FUNC_LOAD);
            cmd.scan_start = req_accept && (req_func == FUNC_ASSIGN);
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_UPDATE: begin
            cmd.update_write = 1'b1;
            cmd.result_load  = status.out_free;
         end
         ST_HOLD: begin
            cmd.result_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/sqa_datapath.sv
// ----------------------------------------------------------------------------
// Shortest queue assigner datapath
// Length memory, scan address counter, running minimum and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shortest_queue_assigner_defines.svh"

module sqa_datapath #(
   parameter int LINES       = sqa_pkg::LINES_DEFAULT,
   parameter int LENGTH_BITS = sqa_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sqa_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sqa_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [sqa_pkg::LINE_COUNT_BITS-1:0]  csr_write_data,
   input  sqa_pkg::cmd_type                     cmd,
   output sqa_pkg::status_type                  status
);
   import sqa_pkg::*;

   localparam int IDX_W = $clog2(LINES);
   localparam int CW    = (IDX_W + 1 > LINE_COUNT_BITS) ? IDX_W + 1 : LINE_COUNT_BITS;

   logic [LENGTH_BITS-1:0]     mem [LINES];

   logic [LINE_COUNT_BITS-1:0] line_count_ff;
   logic [IDX_W-1:0]           scan_addr_ff;
   logic [IDX_W-1:0]           scan_addr_in;
   logic                       rd_valid_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic [LENGTH_BITS-1:0]     rd_data_ff;
   logic [IDX_W-1:0]           best_idx_ff;
   logic [LENGTH_BITS-1:0]     best_len_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   rsp_type                    rsp_data_ff;

   logic [CW-1:0]              lc_ext;
   logic [IDX_W-1:0]           last_idx;
   logic                       load_in_range;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [LENGTH_BITS-1:0]     wr_data;
   logic [LENGTH_BITS-1:0]     best_len_inc;
   logic                       take_new;

   // line_count register: zero acts as one, above LINES acts as LINES
   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= LINE_COUNT_RESET;
      end else if (csr_write_enable) begin
         line_count_ff <= csr_write_data;
      end
   end

   always_comb begin
      lc_ext = CW'(line_count_ff);
      if (lc_ext == '0) begin
         last_idx = '0;
      end else if (lc_ext > CW'(LINES)) begin
         last_idx = IDX_W'(LINES - 1);
      end else begin
         last_idx = IDX_W'(lc_ext - CW'(1));
      end
   end

   // Address counter shared by the clearing pass and the scan
   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
      end else if (cmd.clear_write || cmd.scan_step) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= cmd.scan_step;
      end
   end

   assign status.clear_last = (scan_addr_ff == IDX_W'(LINES - 1));
   assign status.scan_last  = (scan_addr_ff == last_idx);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Write port select
   assign load_in_range = (CW'(req_data.line_index) < CW'(LINES));
   assign best_len_inc  = (best_len_ff == {LENGTH_BITS{1'b1}}) ? best_len_ff
                                                               : best_len_ff + 1'b1;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_addr_ff;
      wr_data = '0;
      if (cmd.clear_write) begin
         wr_en = 1'b1;
      end else if (cmd.load_write) begin
         wr_en   = load_in_range;
         wr_addr = IDX_W'(req_data.line_index);
         wr_data = LENGTH_BITS'(req_data.load_length);
      end else if (cmd.update_write) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = best_len_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[scan_addr_ff];
      rd_idx_ff  <= scan_addr_ff;
   end

   // Running minimum; strict compare keeps the lowest index on ties
   assign take_new = rd_valid_ff && ((rd_idx_ff == '0) || (rd_data_ff < best_len_ff));

   always_ff @(posedge clock) begin
      if (take_new) begin
         best_idx_ff <= rd_idx_ff;
         best_len_ff <= rd_data_ff;
      end
   end

   // Result register
   assign rsp_valid_in = cmd.result_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_data_ff.chosen_line   <= LINE_BITS'(best_idx_ff);
         rsp_data_ff.chosen_length <= LENGTH_OUT_BITS'(best_len_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SQA_ASSERT_NEVER(a_no_result_overwrite, clock, reset,
      cmd.result_load && rsp_valid_ff && rsp_stall, "result overwritten before taken")
   `SQA_ASSERT_NEVER(a_drained_before_writeback, clock, reset,
      cmd.update_write && rd_valid_ff, "write-back while scan data still in flight")
   `SQA_ASSERT_NEVER(a_no_write_during_scan, clock, reset,
      cmd.scan_step && wr_en, "memory written during scan")

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Shortest queue assigner testbench
// Drives load and assign transactions through the request channel, predicts
// each choice with a bank of saturating length counters of its own, and
// compares every response field by field. Bursty sender, random-length receiver
// stalls and several line_count settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import sqa_pkg::*;

   localparam int MAX_REPORTS = 10;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   req_type                     req_data;
   logic                        rsp_valid;
   logic                        rsp_stall;
   rsp_type                     rsp_data;
   logic                        csr_write_enable;
   logic [LINE_COUNT_BITS-1:0]  csr_write_data;

   // Prediction state: one length counter per queue plus the line_count register
   logic [LENGTH_OUT_BITS-1:0]  queue_len_model [LINES_DEFAULT];
   logic [LINE_COUNT_BITS-1:0]  model_line_count;
   rsp_type                     pending_choices [$];
   rsp_type                     expected_choice;

   int unsigned error_count;
   int unsigned choices_checked;
   int unsigned loads_sent;
   int unsigned assigns_sent;
   int unsigned saturated_picks;
   int unsigned count_settings;
   int unsigned burst_left;
   bit          sender_bursty;
   bit          receiver_stalls;
   int unsigned stall_run;

   shortest_queue_assigner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #8_000_000;
      $display("FAIL shortest_queue_assigner");
      $finish;
   end

   // Number of queues the search covers: zero acts as one, clamp to the bank
   function automatic int unsigned active_line_count();
      int unsigned n;
      n = model_line_count;
      if (n == 0) n = 1;
      if (n > LINES_DEFAULT) n = LINES_DEFAULT;
      return n;
   endfunction

   // Apply one accepted transaction to the counter bank; queue the choice it makes
   function automatic void apply_request(req_type item);
      int unsigned               n;
      int unsigned               best;
      logic [LENGTH_OUT_BITS-1:0] best_len;
      rsp_type                   choice;
      if (item.func == FUNC_LOAD) begin
         queue_len_model[item.line_index] = item.load_length;
      end else begin
         n = active_line_count();
         best = 0;
         best_len = queue_len_model[0];
         for (int unsigned i = 1; i < n; i++) begin
            if (queue_len_model[i] < best_len) begin
               best = i;
               best_len = queue_len_model[i];
            end
         end
         choice.chosen_line = LINE_BITS'(best);
         choice.chosen_length = best_len;
         pending_choices.push_back(choice);
         if (best_len != {LENGTH_OUT_BITS{1'b1}})
            queue_len_model[best] = best_len + 1'b1;
         else
            saturated_picks++;
      end
   endfunction

   // Receiver: stall in runs of random length, or never when stalls are off
   always @(negedge clock) begin
      if (!receiver_stalls) begin
         rsp_stall = 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall = ($urandom_range(0, 2) == 0);
         stall_run = rsp_stall ? $urandom_range(0, 15) : $urandom_range(0, 9);
      end
   end

   // Check every response transaction against the oldest pending choice
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_choices.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("ERROR %0t: unexpected response line=%0d length=%0d",
                        $realtime, rsp_data.chosen_line, rsp_data.chosen_length);
         end else begin
            expected_choice = pending_choices.pop_front();
            choices_checked++;
            if (rsp_data.chosen_line !== expected_choice.chosen_line ||
                rsp_data.chosen_length !== expected_choice.chosen_length) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("ERROR %0t: choice %0d expected line=%0d length=%0d, got line=%0d length=%0d",
                           $realtime, choices_checked,
                           expected_choice.chosen_line, expected_choice.chosen_length,
                           rsp_data.chosen_line, rsp_data.chosen_length);
            end
         end
      end
   end

   // Send one transaction; returns at the falling edge after acceptance
   task automatic send_request(input req_type item);
      if (sender_bursty) begin
         if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_data = item;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      apply_request(item);
      if (item.func == FUNC_LOAD) loads_sent++;
      else assigns_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_load(input int unsigned line, input logic [15:0] length);
      req_type item;
      item.func = FUNC_LOAD;
      item.line_index = LINE_BITS'(line);
      item.load_length = length;
      send_request(item);
   endtask

   task automatic send_assign();
      req_type item;
      item.func = FUNC_ASSIGN;
      item.line_index = LINE_BITS'($urandom);
      item.load_length = LENGTH_OUT_BITS'($urandom);
      send_request(item);
   endtask

   // Hold until every pending choice has come back, then let the scan settle
   task automatic wait_until_drained();
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (active_line_count() + 8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_line_count(input logic [LINE_COUNT_BITS-1:0] value);
      wait_until_drained();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      model_line_count = value;
      count_settings++;
   endtask

   task automatic test_reset_defaults();
      // line_count comes up as one: queue 0 is picked and counts up from zero
      send_assign();
      send_assign();
   endtask

   task automatic test_saturation();
      write_line_count(8'd1);
      send_load(0, 16'hFFFE);
      repeat (3) send_assign();
   endtask

   task automatic test_tie_break();
      write_line_count(8'd4);
      send_load(0, 16'd5);
      send_load(1, 16'd3);
      send_load(2, 16'd3);
      send_load(3, 16'd7);
      repeat (3) send_assign();
   endtask

   task automatic test_count_extremes();
      // zero searches queue 0 alone, even with a shorter queue beside it
      write_line_count(8'd0);
      send_load(0, 16'd9);
      send_load(1, 16'd0);
      send_assign();
      // above the bank size acts as the full bank
      write_line_count(8'd255);
      send_load(LINES_DEFAULT - 1, 16'hFFFF);
      send_assign();
      write_line_count(8'd128);
      send_assign();
   endtask

   task automatic test_random_traffic();
      logic [LINE_COUNT_BITS-1:0] phase_counts [10];
      int unsigned                active;
      int unsigned                pick;
      logic [15:0]                length;
      phase_counts = '{8'd3, 8'd1, 8'd16, 8'd0, 8'd128, 8'd2, 8'd255, 8'd40,
                       8'd129, 8'd7};
      phase_counts[9] = LINE_COUNT_BITS'($urandom_range(1, 24));
      for (int p = 0; p < 10; p++) begin
         write_line_count(phase_counts[p]);
         sender_bursty = (p % 3 != 0);
         receiver_stalls = (p % 3 != 1);
         burst_left = 0;
         active = active_line_count();
         for (int k = 0; k < 85; k++) begin
            // pause mid-phase until all choices are back
            if (k == 42) wait_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               pick = $urandom_range(0, 99);
               if (pick < 50) length = 16'($urandom_range(0, 7));
               else if (pick < 70) length = 16'($urandom);
               else if (pick < 85) length = 16'($urandom_range(16'hFFF0, 16'hFFFF));
               else length = '0;
               if ($urandom_range(0, 9) == 0)
                  send_load($urandom_range(0, LINES_DEFAULT - 1), length);
               else
                  send_load($urandom_range(0, active - 1), length);
            end else begin
               send_assign();
            end
         end
      end
      sender_bursty = 1'b0;
      receiver_stalls = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      sender_bursty = 1'b0;
      receiver_stalls = 1'b0;
      burst_left = 0;
      stall_run = 0;
      error_count = 0;
      choices_checked = 0;
      loads_sent = 0;
      assigns_sent = 0;
      saturated_picks = 0;
      count_settings = 0;
      model_line_count = LINE_COUNT_RESET;
      foreach (queue_len_model[i]) queue_len_model[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_saturation();
      test_tie_break();
      test_count_extremes();
      test_random_traffic();
      wait_until_drained();

      $display("Sent %0d transactions (%0d loads, %0d assigns) across %0d line_count writes",
               loads_sent + assigns_sent, loads_sent, assigns_sent, count_settings);
      $display("Checked %0d choices, %0d of them on a saturated counter, %0d errors",
               choices_checked, saturated_picks, error_count);
      if (error_count == 0 && pending_choices.size() == 0) begin
         $display("PASS shortest_queue_assigner");
      end else begin
         $display("FAIL shortest_queue_assigner");
      end
      $finish;
   end

endmodule
